// ===== rtl/lrupr_pkg.sv =====
// shared constants and types for the lru page replacement block
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int FRAMES_DEFAULT    = 8;
    localparam int PAGE_BITS_DEFAULT = 16;

    localparam int CFG_W       = 4;
    localparam int FRAME_OUT_W = 3;
    localparam int COUNT_W     = 16;

    localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RESET = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX           = 16'hFFFF;

    // result status that travels from the core to the output register
    typedef struct packed {
        logic                   page_fault;
        logic [FRAME_OUT_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [COUNT_W-1:0]     fault_count;
    } res_flags_t;

endpackage

// ===== rtl/lrupr_in_reg.sv =====
// input register stage for page references
`timescale 1ns / 1ps

module lrupr_in_reg
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PAGE_BITS-1:0] page_number,
    input  logic                 end_of_string,
    input  logic                 take,
    output logic                 item_valid,
    output logic [PAGE_BITS-1:0] item_page,
    output logic                 item_eos
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 eos_reg;
    logic                 accept;

    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= page_number;
            eos_reg  <= end_of_string;
        end
    end

    assign item_valid = valid_reg;
    assign item_page  = page_reg;
    assign item_eos   = eos_reg;

endmodule

// ===== rtl/lrupr_core.sv =====
// frame table, recency ranks, fault counter and the per-reference update
`timescale 1ns / 1ps

module lrupr_core
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEFAULT,
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 fire,
    input  logic [PAGE_BITS-1:0] item_page,
    input  logic                 item_eos,
    output res_flags_t           res_flags,
    output logic [PAGE_BITS-1:0] res_evicted_page
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    logic [PAGE_BITS-1:0] frame_page_reg [FRAMES];
    logic [FRAMES-1:0]    frame_valid_reg;
    logic [FRAMES-1:0]    frame_valid_next;
    logic [IDX_W-1:0]     rank_reg  [FRAMES];
    logic [IDX_W-1:0]     rank_next [FRAMES];
    logic [CNT_W-1:0]     filled_reg;
    logic [CNT_W-1:0]     filled_next;
    logic [COUNT_W-1:0]   faults_reg;
    logic [COUNT_W-1:0]   faults_next;
    logic [COUNT_W-1:0]   faults_upd;
    logic [CFG_W-1:0]     frames_in_use_reg;

    logic [CNT_W-1:0] limit;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             vic_found;
    logic [IDX_W-1:0] vic_idx;
    logic [IDX_W-1:0] vic_rank;
    logic             fill;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] old_rank;

    // zero acts as one, anything above the frame count acts as the frame count
    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (32'(frames_in_use_reg) > FRAMES)
        begin
            limit = CNT_W'(FRAMES);
        end
        else
        begin
            limit = CNT_W'(frames_in_use_reg);
        end
    end

    // lowest valid frame holding the page
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!hit && frame_valid_reg[i] && frame_page_reg[i] == item_page)
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // oldest valid frame below the limit
    always_comb
    begin
        vic_found = 1'b0;
        vic_idx   = '0;
        vic_rank  = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (CNT_W'(i) < limit && frame_valid_reg[i]
                && (!vic_found || rank_reg[i] > vic_rank))
            begin
                vic_found = 1'b1;
                vic_idx   = IDX_W'(i);
                vic_rank  = rank_reg[i];
            end
        end
    end

    assign fill = !hit && (filled_reg < limit);

    always_comb
    begin
        if (hit)
        begin
            sel      = hit_idx;
            old_rank = rank_reg[hit_idx];
        end
        else if (fill)
        begin
            sel      = IDX_W'(filled_reg);
            old_rank = '0;
        end
        else
        begin
            sel      = vic_idx;
            old_rank = vic_rank;
        end
    end

    assign faults_upd = (!hit && faults_reg != COUNT_MAX) ? faults_reg + COUNT_W'(1)
                                                          : faults_reg;

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        filled_next      = filled_reg;
        faults_next      = faults_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (fire)
        begin
            // selected frame becomes newest, younger valid frames age by one
            for (int i = 0; i < FRAMES; i++)
            begin
                if (IDX_W'(i) == sel)
                begin
                    rank_next[i] = '0;
                end
                else if (frame_valid_reg[i] && (fill || rank_reg[i] < old_rank))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            if (fill)
            begin
                frame_valid_next[sel] = 1'b1;
                filled_next           = filled_reg + CNT_W'(1);
            end
            faults_next = faults_upd;
            if (item_eos)
            begin
                frame_valid_next = '0;
                filled_next      = '0;
                faults_next      = '0;
                for (int i = 0; i < FRAMES; i++)
                begin
                    rank_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg   <= '0;
            filled_reg        <= '0;
            faults_reg        <= '0;
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
            filled_reg      <= filled_next;
            faults_reg      <= faults_next;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (cfg_wr_en)
            begin
                frames_in_use_reg <= cfg_wr_data;
            end
        end
    end

    // page tags, read only while the frame is valid
    always_ff @(posedge clk)
    begin
        if (fire && !hit)
        begin
            frame_page_reg[sel] <= item_page;
        end
    end

    always_comb
    begin
        res_flags.page_fault    = !hit;
        res_flags.frame_index   = FRAME_OUT_W'(sel);
        res_flags.evicted_valid = !hit && !fill;
        res_flags.fault_count   = faults_upd;
        res_evicted_page        = (!hit && !fill) ? frame_page_reg[vic_idx] : '0;
    end

endmodule

// ===== rtl/lrupr_out_reg.sv =====
// result register for the outgoing beat
`timescale 1ns / 1ps

module lrupr_out_reg
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  res_flags_t             res_flags,
    input  logic [PAGE_BITS-1:0]   res_evicted_page,
    output logic                   ready,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   page_fault,
    output logic [FRAME_OUT_W-1:0] frame_index,
    output logic                   evicted_valid,
    output logic [PAGE_BITS-1:0]   evicted_page,
    output logic [COUNT_W-1:0]     fault_count
);

    logic                 valid_reg;
    logic                 valid_next;
    res_flags_t           flags_reg;
    logic [PAGE_BITS-1:0] ev_page_reg;

    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg   <= res_flags;
            ev_page_reg <= res_evicted_page;
        end
    end

    assign out_valid     = valid_reg;
    assign page_fault    = flags_reg.page_fault;
    assign frame_index   = flags_reg.frame_index;
    assign evicted_valid = flags_reg.evicted_valid;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = flags_reg.fault_count;

endmodule

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement: a fully associative set of page frames with an
// exact recency order. One reference beat is taken per clock cycle, back to
// back, while out_stall is low, and each yields exactly one result beat
// (input register, then combinational lookup, victim pick and recency
// update into the result register). The rate is set by the update loop over
// the frame table: every frame is compared in parallel for a hit, the
// oldest frame below the limit is picked, and all ranks are refreshed before
// the next reference reaches the table. frames_in_use (4 bits, reset 8) caps
// how many frames a string may fill; zero acts as one, values above FRAMES
// act as FRAMES. Write it only while the block is idle. A beat marked
// end_of_string returns its result and then clears the frames and the fault
// count; frames_in_use is kept. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEFAULT,
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    // reference beats
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PAGE_BITS-1:0]   page_number,
    input  logic                   end_of_string,
    // result beats
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   page_fault,
    output logic [FRAME_OUT_W-1:0] frame_index,
    output logic                   evicted_valid,
    output logic [PAGE_BITS-1:0]   evicted_page,
    output logic [COUNT_W-1:0]     fault_count
);

    logic                 item_valid;
    logic [PAGE_BITS-1:0] item_page;
    logic                 item_eos;
    logic                 out_ready;
    logic                 take;
    res_flags_t           res_flags;
    logic [PAGE_BITS-1:0] res_evicted_page;

    // a held reference moves on whenever the result register can take it
    assign take = item_valid && out_ready;

    lrupr_in_reg #(
        .PAGE_BITS (PAGE_BITS)
    ) u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .end_of_string (end_of_string),
        .take          (take),
        .item_valid    (item_valid),
        .item_page     (item_page),
        .item_eos      (item_eos)
    );

    // frame table and recency state, updated once per reference
    lrupr_core #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .fire             (take),
        .item_page        (item_page),
        .item_eos         (item_eos),
        .res_flags        (res_flags),
        .res_evicted_page (res_evicted_page)
    );

    // result register decouples the table from a stalled consumer
    lrupr_out_reg #(
        .PAGE_BITS (PAGE_BITS)
    ) u_out_reg (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (take),
        .res_flags        (res_flags),
        .res_evicted_page (res_evicted_page),
        .ready            (out_ready),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .page_fault       (page_fault),
        .frame_index      (frame_index),
        .evicted_valid    (evicted_valid),
        .evicted_page     (evicted_page),
        .fault_count      (fault_count)
    );

endmodule
